[hdl/blrs_pkg.sv]
// Package of shared widths, codes and the result type of the best-lag search.
package blrs_pkg;

    // Field widths of the sample and result items.
    localparam int SAMPLE_W = 16;
    localparam int ENTRY_W  = SAMPLE_W + 1;
    localparam int OFF_W    = 12;
    localparam int SCORE_W  = 17;

    // Width of the exact score fractions and of their products.
    localparam int WIDE_W = 96;
    localparam int PROD_W = 2 * WIDE_W;

    // Series codes carried in the op field.
    localparam logic OP_BASE = 1'b0;
    localparam logic OP_FIT  = 1'b1;

    // One search result as it leaves the search engine.
    typedef struct packed {
        logic                      found;
        logic signed [OFF_W-1:0]   best_offset;
        logic        [SCORE_W-1:0] best_r_squared;
    } result_t;

endpackage

[hdl/blrs_in_if.sv]
// Sample channel: valid, ready and one sample item.
interface blrs_in_if;
    import blrs_pkg::*;

    logic                       valid;
    logic                       ready;
    logic                       op;
    logic signed [SAMPLE_W-1:0] sample;
    logic                       sample_valid;
    logic                       last;

    modport source (output valid, output op, output sample, output sample_valid,
                    output last, input ready);
    modport sink   (input valid, input op, input sample, input sample_valid,
                    input last, output ready);
endinterface

[hdl/blrs_out_if.sv]
// Result channel: valid, ready and one search result item.
interface blrs_out_if;
    import blrs_pkg::*;

    logic                      valid;
    logic                      ready;
    logic                      found;
    logic signed [OFF_W-1:0]   best_offset;
    logic        [SCORE_W-1:0] best_r_squared;

    modport source (output valid, output found, output best_offset,
                    output best_r_squared, input ready);
    modport sink   (input valid, input found, input best_offset,
                    input best_r_squared, output ready);
endinterface

[hdl/blrs_store.sv]
// Sample stores for the base and fit series, with their length counters.
module blrs_store #(
    parameter int MAX_BASE = 4096,
    parameter int MAX_FIT  = 4096
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 wr_en,
    input  logic                                 op,
    input  logic [blrs_pkg::ENTRY_W-1:0]         entry,
    input  logic                                 last,
    output logic                                 start,
    output logic [$clog2(MAX_BASE+1)-1:0]        start_n,
    output logic [$clog2(MAX_FIT+1)-1:0]         start_m,
    output logic [$clog2(MAX_BASE+1)-1:0]        start_radius,
    input  logic                                 base_rd_en,
    input  logic [$clog2(MAX_BASE)-1:0]          base_rd_addr,
    output logic [blrs_pkg::ENTRY_W-1:0]         base_rd_data,
    input  logic                                 fit_rd_en,
    input  logic [$clog2(MAX_FIT)-1:0]           fit_rd_addr,
    output logic [blrs_pkg::ENTRY_W-1:0]         fit_rd_data
);
    import blrs_pkg::*;

    localparam int LB_W = $clog2(MAX_BASE + 1);
    localparam int LF_W = $clog2(MAX_FIT + 1);
    localparam int AB_W = $clog2(MAX_BASE);
    localparam int AF_W = $clog2(MAX_FIT);

    logic [ENTRY_W-1:0] base_mem [MAX_BASE];
    logic [ENTRY_W-1:0] fit_mem  [MAX_FIT];
    logic [ENTRY_W-1:0] base_rd_data_reg;
    logic [ENTRY_W-1:0] fit_rd_data_reg;

    logic [LB_W-1:0] base_len_reg, base_len_next;
    logic [LB_W-1:0] rad_reg, rad_next;
    logic [1:0]      mod3_reg, mod3_next;
    logic            closed_reg, closed_next;
    logic [LF_W-1:0] fit_len_reg, fit_len_next;

    logic            base_we, fit_we;
    logic [AB_W-1:0] base_wr_addr;
    logic [LB_W-1:0] len0, rad0;
    logic [1:0]      mod30;
    logic [LF_W-1:0] fit_len_inc;

    // Length, radius and close flag updates for each accepted item.
    always_comb
    begin
        base_len_next = base_len_reg;
        rad_next      = rad_reg;
        mod3_next     = mod3_reg;
        closed_next   = closed_reg;
        fit_len_next  = fit_len_reg;
        base_we       = 1'b0;
        fit_we        = 1'b0;
        start         = 1'b0;
        len0          = closed_reg ? '0 : base_len_reg;
        rad0          = closed_reg ? '0 : rad_reg;
        mod30         = closed_reg ? 2'd0 : mod3_reg;
        base_wr_addr  = len0[AB_W-1:0];
        fit_len_inc   = (fit_len_reg < LF_W'(MAX_FIT)) ? fit_len_reg + 1'b1 : fit_len_reg;
        if (wr_en && op == OP_BASE)
        begin
            base_len_next = len0;
            rad_next      = rad0;
            mod3_next     = mod30;
            if (len0 < LB_W'(MAX_BASE))
            begin
                base_we       = 1'b1;
                base_len_next = len0 + 1'b1;
                // The radius is the length divided by three, kept as it grows.
                if (mod30 == 2'd2)
                begin
                    mod3_next = 2'd0;
                    rad_next  = rad0 + 1'b1;
                end
                else
                begin
                    mod3_next = mod30 + 2'd1;
                end
            end
            closed_next = last;
        end
        else if (wr_en && op == OP_FIT)
        begin
            fit_we       = fit_len_reg < LF_W'(MAX_FIT);
            fit_len_next = fit_len_inc;
            if (last)
            begin
                start        = 1'b1;
                fit_len_next = '0;
            end
        end
    end

    assign start_n      = base_len_reg;
    assign start_radius = rad_reg;
    assign start_m      = fit_len_inc;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_len_reg <= '0;
            rad_reg      <= '0;
            mod3_reg     <= 2'd0;
            closed_reg   <= 1'b0;
            fit_len_reg  <= '0;
        end
        else
        begin
            base_len_reg <= base_len_next;
            rad_reg      <= rad_next;
            mod3_reg     <= mod3_next;
            closed_reg   <= closed_next;
            fit_len_reg  <= fit_len_next;
        end
    end

    // Base memory: one write and one registered read port.
    always_ff @(posedge clk)
    begin
        if (base_we)
        begin
            base_mem[base_wr_addr] <= entry;
        end
        if (base_rd_en)
        begin
            base_rd_data_reg <= base_mem[base_rd_addr];
        end
    end

    // Fit memory: one write and one registered read port.
    always_ff @(posedge clk)
    begin
        if (fit_we)
        begin
            fit_mem[fit_len_reg[AF_W-1:0]] <= entry;
        end
        if (fit_rd_en)
        begin
            fit_rd_data_reg <= fit_mem[fit_rd_addr];
        end
    end

    assign base_rd_data = base_rd_data_reg;
    assign fit_rd_data  = fit_rd_data_reg;

endmodule

[hdl/blrs_mul.sv]
// Bit-serial wide multiplier for the exact score fractions.
module blrs_mul (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [blrs_pkg::WIDE_W-1:0] a,
    input  logic [blrs_pkg::WIDE_W-1:0] b,
    output logic                        done,
    output logic [blrs_pkg::PROD_W-1:0] p
);
    import blrs_pkg::*;

    localparam int CW = $clog2(WIDE_W + 1);

    logic [PROD_W-1:0] a_reg, a_next;
    logic [WIDE_W-1:0] b_reg, b_next;
    logic [PROD_W-1:0] acc_reg, acc_next;
    logic [CW-1:0]     cnt_reg, cnt_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;

    // One multiplier bit per cycle: add the shifted multiplicand if set.
    always_comb
    begin
        a_next    = a_reg;
        b_next    = b_reg;
        acc_next  = acc_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            a_next    = PROD_W'(a);
            b_next    = b;
            acc_next  = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (b_reg[0])
            begin
                acc_next = acc_reg + a_reg;
            end
            a_next   = a_reg << 1;
            b_next   = b_reg >> 1;
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CW'(WIDE_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg   <= a_next;
        b_reg   <= b_next;
        acc_reg <= acc_next;
    end

    assign done = done_reg;
    assign p    = acc_reg;

endmodule

[hdl/blrs_search.sv]
// Lag search sequencer: reads the stores, builds exact sums and keeps the best score.
module blrs_search #(
    parameter int MAX_BASE = 4096,
    parameter int MAX_FIT  = 4096
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [$clog2(MAX_BASE+1)-1:0] start_n,
    input  logic [$clog2(MAX_FIT+1)-1:0]  start_m,
    input  logic [$clog2(MAX_BASE+1)-1:0] start_radius,
    output logic                          busy,
    output logic                          base_rd_en,
    output logic [$clog2(MAX_BASE)-1:0]   base_rd_addr,
    input  logic [blrs_pkg::ENTRY_W-1:0]  base_rd_data,
    output logic                          fit_rd_en,
    output logic [$clog2(MAX_FIT)-1:0]    fit_rd_addr,
    input  logic [blrs_pkg::ENTRY_W-1:0]  fit_rd_data,
    output logic                          res_valid,
    input  logic                          res_ready,
    output blrs_pkg::result_t             res
);
    import blrs_pkg::*;

    localparam int LB_W  = $clog2(MAX_BASE + 1);
    localparam int LF_W  = $clog2(MAX_FIT + 1);
    localparam int AB_W  = $clog2(MAX_BASE);
    localparam int AF_W  = $clog2(MAX_FIT);
    localparam int IW    = ((LB_W > LF_W) ? LB_W : LF_W) + 2;
    localparam int CB_W  = LB_W + SAMPLE_W + 1;
    localparam int H     = (CB_W + 1) / 2;
    localparam int MH    = CB_W - H;
    localparam int RES_W = 2 * (SAMPLE_W + 1) + LF_W;
    localparam int DC_W  = $clog2(SCORE_W + 1);
    localparam logic signed [IW-1:0] ONE = IW'(1);

    localparam logic [4:0] S_IDLE   = 5'd0;
    localparam logic [4:0] S_LAG    = 5'd1;
    localparam logic [4:0] S_MRD    = 5'd2;
    localparam logic [4:0] S_MAC    = 5'd3;
    localparam logic [4:0] S_ORD    = 5'd4;
    localparam logic [4:0] S_OA     = 5'd5;
    localparam logic [4:0] S_OB     = 5'd6;
    localparam logic [4:0] S_OC     = 5'd7;
    localparam logic [4:0] S_OD     = 5'd8;
    localparam logic [4:0] S_OE     = 5'd9;
    localparam logic [4:0] S_OF     = 5'd10;
    localparam logic [4:0] S_CHK    = 5'd11;
    localparam logic [4:0] S_RESC   = 5'd12;
    localparam logic [4:0] S_RESC_W = 5'd13;
    localparam logic [4:0] S_P1     = 5'd14;
    localparam logic [4:0] S_P1_W   = 5'd15;
    localparam logic [4:0] S_P2     = 5'd16;
    localparam logic [4:0] S_P2_W   = 5'd17;
    localparam logic [4:0] S_NEXT   = 5'd18;
    localparam logic [4:0] S_DIV    = 5'd19;
    localparam logic [4:0] S_DONE   = 5'd20;

    logic [4:0] state_reg, state_next;

    logic        [LB_W-1:0]     n_reg, n_next;
    logic        [LF_W-1:0]     m_reg, m_next;
    logic        [LB_W-1:0]     rad_reg, rad_next;
    logic signed [IW-1:0]       lag_reg, lag_next;
    logic signed [IW-1:0]       i_reg, i_next;
    logic signed [IW-1:0]       lo_reg, lo_next;
    logic signed [IW-1:0]       hi_reg, hi_next;
    logic        [LB_W-1:0]     cnt_reg, cnt_next;
    logic signed [CB_W-1:0]     s_reg, s_next;
    logic        [RES_W-1:0]    sres_reg, sres_next;
    logic        [WIDE_W-1:0]   tot_reg, tot_next;
    logic signed [CB_W-1:0]     cb_reg, cb_next;
    logic        [CB_W-1:0]     mag_reg, mag_next;
    logic        [2*H-1:0]      sq_reg, sq_next;
    logic                       first_reg, first_next;
    logic signed [SAMPLE_W-1:0] b0_reg, b0_next;
    logic signed [SAMPLE_W-1:0] f0_reg, f0_next;
    logic                       bv_reg, bv_next;
    logic                       fv_reg, fv_next;
    logic        [2*LB_W-1:0]   cnt2_reg, cnt2_next;
    logic        [WIDE_W-1:0]   num_reg, num_next;
    logic        [PROD_W-1:0]   p1_reg, p1_next;
    logic        [WIDE_W-1:0]   best_num_reg, best_num_next;
    logic        [WIDE_W-1:0]   best_den_reg, best_den_next;
    logic signed [IW-1:0]       best_lag_reg, best_lag_next;
    logic                       found_reg, found_next;
    logic        [WIDE_W:0]     rem_reg, rem_next;
    logic        [SCORE_W-1:0]  q_reg, q_next;
    logic        [DC_W-1:0]     div_cnt_reg, div_cnt_next;

    logic                       mul_start;
    logic        [WIDE_W-1:0]   mul_a, mul_b;
    logic                       mul_done;
    logic        [PROD_W-1:0]   mul_p;

    logic signed [IW-1:0]       n_s, m_s, rad_s, ms, lo, hi, nl, bidx;
    logic signed [SAMPLE_W-1:0] bs, fs;
    logic signed [SAMPLE_W:0]   d;
    logic signed [2*SAMPLE_W+1:0] dd;
    logic signed [CB_W:0]       dc;
    logic        [CB_W:0]       dc_abs;
    logic        [MH-1:0]       mh;
    logic        [H-1:0]        ml;
    logic        [WIDE_W-1:0]   resc;
    logic        [WIDE_W:0]     cur, den_ext;

    blrs_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .a     (mul_a),
        .b     (mul_b),
        .done  (mul_done),
        .p     (mul_p)
    );

    // Signed views of the lengths and the per-lag ranges.
    always_comb
    begin
        n_s   = $signed(IW'(n_reg));
        m_s   = $signed(IW'(m_reg));
        rad_s = $signed(IW'(rad_reg));
        ms    = (lag_reg > ONE) ? lag_reg : ONE;
        lo    = ((ONE - lag_reg) > $signed(IW'(0))) ? ONE - lag_reg : $signed(IW'(0));
        nl    = n_s - lag_reg;
        hi    = (m_s < nl) ? m_s : nl;
        bidx  = i_reg + lag_reg;
    end

    // Sample arithmetic of the overlap pass.
    always_comb
    begin
        bs      = $signed(base_rd_data[SAMPLE_W-1:0]);
        fs      = $signed(fit_rd_data[SAMPLE_W-1:0]);
        d       = {bs[SAMPLE_W-1], bs} - {fs[SAMPLE_W-1], fs};
        dd      = d * d;
        dc      = {cb_reg[CB_W-1], cb_reg} - {s_reg[CB_W-1], s_reg};
        dc_abs  = dc[CB_W] ? $unsigned(-dc) : $unsigned(dc);
        mh      = mag_reg[CB_W-1:H];
        ml      = mag_reg[H-1:0];
        resc    = mul_p[WIDE_W-1:0];
        den_ext = {1'b0, best_den_reg};
        cur     = (div_cnt_reg == DC_W'(SCORE_W)) ? rem_reg : {rem_reg[WIDE_W-1:0], 1'b0};
    end

    // Memory read ports.
    always_comb
    begin
        base_rd_en   = (state_reg == S_MRD) || (state_reg == S_ORD);
        base_rd_addr = (state_reg == S_MRD) ? i_reg[AB_W-1:0] : bidx[AB_W-1:0];
        fit_rd_en    = (state_reg == S_ORD);
        fit_rd_addr  = i_reg[AF_W-1:0];
    end

    // Search sequencer.
    always_comb
    begin
        state_next    = state_reg;
        n_next        = n_reg;
        m_next        = m_reg;
        rad_next      = rad_reg;
        lag_next      = lag_reg;
        i_next        = i_reg;
        lo_next       = lo_reg;
        hi_next       = hi_reg;
        cnt_next      = cnt_reg;
        s_next        = s_reg;
        sres_next     = sres_reg;
        tot_next      = tot_reg;
        cb_next       = cb_reg;
        mag_next      = mag_reg;
        sq_next       = sq_reg;
        first_next    = first_reg;
        b0_next       = b0_reg;
        f0_next       = f0_reg;
        bv_next       = bv_reg;
        fv_next       = fv_reg;
        cnt2_next     = cnt2_reg;
        num_next      = num_reg;
        p1_next       = p1_reg;
        best_num_next = best_num_reg;
        best_den_next = best_den_reg;
        best_lag_next = best_lag_reg;
        found_next    = found_reg;
        rem_next      = rem_reg;
        q_next        = q_reg;
        div_cnt_next  = div_cnt_reg;
        mul_start     = 1'b0;
        mul_a         = num_reg;
        mul_b         = best_den_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    n_next        = start_n;
                    m_next        = start_m;
                    rad_next      = start_radius;
                    lag_next      = -$signed(IW'(start_radius));
                    best_num_next = '0;
                    best_den_next = WIDE_W'(1);
                    best_lag_next = '0;
                    found_next    = 1'b0;
                    q_next        = '0;
                    state_next    = (start_radius == '0) ? S_DONE : S_LAG;
                end
            end
            S_LAG:
            begin
                // Skip lags with an empty overlap before touching the stores.
                if (ms >= n_s || lo >= hi)
                begin
                    state_next = S_NEXT;
                end
                else
                begin
                    cnt_next   = LB_W'(n_s - ms);
                    lo_next    = lo;
                    hi_next    = hi;
                    i_next     = ms;
                    s_next     = '0;
                    state_next = S_MRD;
                end
            end
            S_MRD:
            begin
                state_next = S_MAC;
            end
            S_MAC:
            begin
                // Mean pass over the base tail; an invalid sample drops the lag.
                if (!base_rd_data[SAMPLE_W])
                begin
                    state_next = S_NEXT;
                end
                else
                begin
                    s_next = s_reg + {{(CB_W-SAMPLE_W){bs[SAMPLE_W-1]}}, bs};
                    i_next = i_reg + ONE;
                    if (i_reg + ONE == n_s)
                    begin
                        i_next     = lo_reg;
                        sres_next  = '0;
                        tot_next   = '0;
                        first_next = 1'b1;
                        bv_next    = 1'b0;
                        fv_next    = 1'b0;
                        state_next = S_ORD;
                    end
                    else
                    begin
                        state_next = S_MRD;
                    end
                end
            end
            S_ORD:
            begin
                state_next = S_OA;
            end
            S_OA:
            begin
                // Residual term and the scaled base sample.
                if (!fit_rd_data[SAMPLE_W])
                begin
                    state_next = S_NEXT;
                end
                else
                begin
                    sres_next = sres_reg + RES_W'($unsigned(dd[2*SAMPLE_W+1:0]));
                    cb_next   = $signed({1'b0, cnt_reg}) * bs;
                    if (first_reg)
                    begin
                        b0_next    = bs;
                        f0_next    = fs;
                        first_next = 1'b0;
                    end
                    else
                    begin
                        bv_next = bv_reg || (bs != b0_reg);
                        fv_next = fv_reg || (fs != f0_reg);
                    end
                    state_next = S_OB;
                end
            end
            S_OB:
            begin
                mag_next   = dc_abs[CB_W-1:0];
                state_next = S_OC;
            end
            S_OC:
            begin
                sq_next    = ml * ml;
                state_next = S_OD;
            end
            S_OD:
            begin
                tot_next   = tot_reg + WIDE_W'(sq_reg);
                sq_next    = (2*H)'(mh * ml);
                state_next = S_OE;
            end
            S_OE:
            begin
                tot_next   = tot_reg + (WIDE_W'(sq_reg) << (H + 1));
                sq_next    = (2*H)'(mh * mh);
                state_next = S_OF;
            end
            S_OF:
            begin
                tot_next = tot_reg + (WIDE_W'(sq_reg) << (2 * H));
                i_next   = i_reg + ONE;
                state_next = (i_reg + ONE == hi_reg) ? S_CHK : S_ORD;
            end
            S_CHK:
            begin
                // Constant sides or a zero total drop the lag.
                if (!bv_reg || !fv_reg || tot_reg == '0)
                begin
                    state_next = S_NEXT;
                end
                else
                begin
                    cnt2_next  = cnt_reg * cnt_reg;
                    state_next = S_RESC;
                end
            end
            S_RESC:
            begin
                mul_start  = 1'b1;
                mul_a      = WIDE_W'(sres_reg);
                mul_b      = WIDE_W'(cnt2_reg);
                state_next = S_RESC_W;
            end
            S_RESC_W:
            begin
                if (mul_done)
                begin
                    if (resc >= tot_reg)
                    begin
                        state_next = S_NEXT;
                    end
                    else
                    begin
                        num_next   = tot_reg - resc;
                        state_next = S_P1;
                    end
                end
            end
            S_P1:
            begin
                mul_start  = 1'b1;
                mul_a      = num_reg;
                mul_b      = best_den_reg;
                state_next = S_P1_W;
            end
            S_P1_W:
            begin
                if (mul_done)
                begin
                    p1_next    = mul_p;
                    state_next = S_P2;
                end
            end
            S_P2:
            begin
                mul_start  = 1'b1;
                mul_a      = best_num_reg;
                mul_b      = tot_reg;
                state_next = S_P2_W;
            end
            S_P2_W:
            begin
                // A strictly higher score replaces the best; ties keep the lower lag.
                if (mul_done)
                begin
                    if (p1_reg > mul_p)
                    begin
                        best_num_next = num_reg;
                        best_den_next = tot_reg;
                        best_lag_next = lag_reg;
                        found_next    = 1'b1;
                    end
                    state_next = S_NEXT;
                end
            end
            S_NEXT:
            begin
                if (lag_reg + ONE == rad_s)
                begin
                    if (found_reg)
                    begin
                        rem_next     = {1'b0, best_num_reg};
                        div_cnt_next = DC_W'(SCORE_W);
                        q_next       = '0;
                        state_next   = S_DIV;
                    end
                    else
                    begin
                        state_next = S_DONE;
                    end
                end
                else
                begin
                    lag_next   = lag_reg + ONE;
                    state_next = S_LAG;
                end
            end
            S_DIV:
            begin
                // Restoring division, one quotient bit per cycle.
                if (cur >= den_ext)
                begin
                    rem_next = cur - den_ext;
                    q_next   = {q_reg[SCORE_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next = cur;
                    q_next   = {q_reg[SCORE_W-2:0], 1'b0};
                end
                div_cnt_next = div_cnt_reg - 1'b1;
                if (div_cnt_reg == DC_W'(1))
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            found_reg    <= 1'b0;
            q_reg        <= '0;
            best_lag_reg <= '0;
            best_num_reg <= '0;
            best_den_reg <= WIDE_W'(1);
            div_cnt_reg  <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            found_reg    <= found_next;
            q_reg        <= q_next;
            best_lag_reg <= best_lag_next;
            best_num_reg <= best_num_next;
            best_den_reg <= best_den_next;
            div_cnt_reg  <= div_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg     <= n_next;
        m_reg     <= m_next;
        rad_reg   <= rad_next;
        lag_reg   <= lag_next;
        i_reg     <= i_next;
        lo_reg    <= lo_next;
        hi_reg    <= hi_next;
        cnt_reg   <= cnt_next;
        s_reg     <= s_next;
        sres_reg  <= sres_next;
        tot_reg   <= tot_next;
        cb_reg    <= cb_next;
        mag_reg   <= mag_next;
        sq_reg    <= sq_next;
        first_reg <= first_next;
        b0_reg    <= b0_next;
        f0_reg    <= f0_next;
        bv_reg    <= bv_next;
        fv_reg    <= fv_next;
        cnt2_reg  <= cnt2_next;
        num_reg   <= num_next;
        p1_reg    <= p1_next;
        rem_reg   <= rem_next;
    end

    assign busy                = (state_reg != S_IDLE);
    assign res_valid           = (state_reg == S_DONE);
    assign res.found           = found_reg;
    assign res.best_offset     = OFF_W'(best_lag_reg);
    assign res.best_r_squared  = q_reg;

    // A search only starts while the sequencer is idle.
    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> state_reg == S_IDLE)
        else $error("search started while busy");

    // Multiplier results arrive only while a product is awaited.
    a_mul_done: assert property (@(posedge clk) disable iff (!rst_n)
        mul_done |-> (state_reg == S_RESC_W || state_reg == S_P1_W ||
                      state_reg == S_P2_W))
        else $error("unexpected multiplier result");

    // Without a winning lag the result reads all zero.
    a_empty_result: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE && !found_reg) |-> (q_reg == '0 && best_lag_reg == '0))
        else $error("nonzero result without a winning lag");

    // The division remainder never exceeds the denominator.
    a_div_rem: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_DIV |-> rem_reg <= den_ext)
        else $error("division remainder out of range");

endmodule

[hdl/best_lag_r_squared_search_top.sv]
// Top level of the best-lag r-squared search: stores, search engine and result register.
//
//   channel   direction  item
//   samples   in         op, sample, sample_valid, last
//   results   out        found, best_offset, best_r_squared
//
// Samples load at one item per cycle into the base and fit memories.
// A fit item with last set starts the search; samples wait while it runs.
// The search time per lag is set by the single read port of each memory and
// the shared bit-serial multiplier; a restoring division ends a search that
// found a winning lag.
// Reset clears lengths and control; the memories are not cleared.
// The result waits in an output register while the next series loads.
module best_lag_r_squared_search_top #(
    parameter int MAX_BASE = 4096,
    parameter int MAX_FIT  = 4096
) (
    input  logic       clk,
    input  logic       rst_n,
    blrs_in_if.sink    samples,
    blrs_out_if.source results
);
    import blrs_pkg::*;

    localparam int LB_W = $clog2(MAX_BASE + 1);
    localparam int LF_W = $clog2(MAX_FIT + 1);
    localparam int AB_W = $clog2(MAX_BASE);
    localparam int AF_W = $clog2(MAX_FIT);

    logic               accept;
    logic               start;
    logic [LB_W-1:0]    start_n, start_radius;
    logic [LF_W-1:0]    start_m;
    logic               busy;
    logic               base_rd_en, fit_rd_en;
    logic [AB_W-1:0]    base_rd_addr;
    logic [AF_W-1:0]    fit_rd_addr;
    logic [ENTRY_W-1:0] base_rd_data, fit_rd_data;
    logic               res_valid, res_ready;
    result_t            res;
    logic               out_valid_reg, out_valid_next;
    result_t            out_item_reg;

    // Samples are taken whenever no search is running.
    assign samples.ready = !busy;
    assign accept        = samples.valid && samples.ready;

    blrs_store #(
        .MAX_BASE (MAX_BASE),
        .MAX_FIT  (MAX_FIT)
    ) u_store (
        .clk          (clk),
        .rst_n        (rst_n),
        .wr_en        (accept),
        .op           (samples.op),
        .entry        ({samples.sample_valid, samples.sample}),
        .last         (samples.last),
        .start        (start),
        .start_n      (start_n),
        .start_m      (start_m),
        .start_radius (start_radius),
        .base_rd_en   (base_rd_en),
        .base_rd_addr (base_rd_addr),
        .base_rd_data (base_rd_data),
        .fit_rd_en    (fit_rd_en),
        .fit_rd_addr  (fit_rd_addr),
        .fit_rd_data  (fit_rd_data)
    );

    blrs_search #(
        .MAX_BASE (MAX_BASE),
        .MAX_FIT  (MAX_FIT)
    ) u_search (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .start_n      (start_n),
        .start_m      (start_m),
        .start_radius (start_radius),
        .busy         (busy),
        .base_rd_en   (base_rd_en),
        .base_rd_addr (base_rd_addr),
        .base_rd_data (base_rd_data),
        .fit_rd_en    (fit_rd_en),
        .fit_rd_addr  (fit_rd_addr),
        .fit_rd_data  (fit_rd_data),
        .res_valid    (res_valid),
        .res_ready    (res_ready),
        .res          (res)
    );

    // Output register: loads when empty or being drained.
    assign res_ready = !out_valid_reg || results.ready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (res_valid && res_ready)
        begin
            out_valid_next = 1'b1;
        end
        else if (results.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            out_item_reg <= res;
        end
    end

    assign results.valid          = out_valid_reg;
    assign results.found          = out_item_reg.found;
    assign results.best_offset    = out_item_reg.best_offset;
    assign results.best_r_squared = out_item_reg.best_r_squared;

endmodule
